### sv/dcss_pkg.sv
// Shared types and constants for the divisor count and sum sieve.
// Holds table geometry, status codes, request/result payloads and the
// command/status bundles between controller and datapath. No dependencies.
package dcss_pkg;

  localparam int MAX_N    = 65536;
  localparam int ADDR_W   = $clog2(MAX_N + 1);
  localparam int LIMIT_W  = 17;
  localparam int COUNT_W  = 8;
  localparam int SUM_W    = 20;
  localparam int STATUS_W = 2;
  localparam int MAXW_A   = (ADDR_W > LIMIT_W) ? ADDR_W : LIMIT_W;
  localparam int ACC_W    = ((MAXW_A > SUM_W) ? MAXW_A : SUM_W) + 1;
  localparam int PADDR_W  = 2;
  localparam int PDATA_W  = 32;

  localparam logic [COUNT_W-1:0]  COUNT_MAX   = '1;
  localparam logic [SUM_W-1:0]    SUM_MAX     = '1;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET = LIMIT_W'(65536);
  localparam logic [PADDR_W-1:0]  REG_LIMIT   = '0;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BUILT = 2'd2;

  localparam logic FUNC_BUILD = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic               func;
    logic [LIMIT_W-1:0] query_value;
  } request_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  divisor_count;
    logic [SUM_W-1:0]    divisor_sum;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic load_build;
    logic load_query;
    logic fill_wr;
    logic rmw_wr;
    logic finish_build;
    logic finish_query;
  } dp_cmd_t;

  typedef struct packed {
    logic top_zero;
    logic j_at_top;
    logic jn_over;
    logic i_next_over;
  } dp_stat_t;

endpackage

### sv/dcss_ctrl.sv
// Sequencer for the divisor sieve: steps builds and queries.
// Depends on dcss_pkg; drives dcss_datapath through dp_cmd_t.
module dcss_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               func,
  input  dcss_pkg::dp_stat_t stat,
  output dcss_pkg::dp_cmd_t  cmd,
  output logic               busy
);
  import dcss_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FILL  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_WR    = 7'b0001000,
    S_BDONE = 7'b0010000,
    S_QRD   = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (func == FUNC_BUILD) begin
            cmd.load_build = 1'b1;
            state_next     = stat.top_zero ? S_BDONE : S_FILL;
          end else begin
            cmd.load_query = 1'b1;
            state_next     = S_QRD;
          end
        end
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (stat.j_at_top) begin
          state_next = stat.i_next_over ? S_BDONE : S_RD;
        end
      end
      S_RD: begin
        state_next = S_WR;
      end
      S_WR: begin
        cmd.rmw_wr = 1'b1;
        state_next = (stat.jn_over && stat.i_next_over) ? S_BDONE : S_RD;
      end
      S_BDONE: begin
        cmd.finish_build = 1'b1;
        state_next       = S_IDLE;
      end
      S_QRD: begin
        cmd.finish_query = 1'b1;
        state_next       = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

### sv/dcss_datapath.sv
// Datapath for the divisor sieve: count and sum tables, divisor and
// multiple counters, saturating update and result register.
// Depends on dcss_pkg; commanded by dcss_ctrl.
module dcss_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  dcss_pkg::dp_cmd_t             cmd,
  input  dcss_pkg::request_t            request,
  input  logic [dcss_pkg::LIMIT_W-1:0]  limit,
  output dcss_pkg::dp_stat_t            stat,
  output dcss_pkg::result_t             result,
  output logic                          done
);
  import dcss_pkg::*;

  logic [COUNT_W-1:0] count_mem [0:MAX_N];
  logic [SUM_W-1:0]   sum_mem   [0:MAX_N];

  logic [ADDR_W-1:0]  i, j, top, built_limit;
  logic [COUNT_W-1:0] rd_count;
  logic [SUM_W-1:0]   rd_sum;
  logic               query_bad;

  logic [ADDR_W-1:0]  rd_addr;
  logic [ACC_W-1:0]   j_plus_i, i_plus1, sum_acc, lim_ext, q_ext;
  logic [ADDR_W-1:0]  top_next;
  logic [COUNT_W-1:0] wr_count;
  logic [SUM_W-1:0]   wr_sum;
  logic               we;

  assign lim_ext  = ACC_W'(limit);
  assign q_ext    = ACC_W'(request.query_value);
  assign top_next = (lim_ext > ACC_W'(MAX_N)) ? ADDR_W'(MAX_N) : ADDR_W'(limit);
  assign j_plus_i = ACC_W'(j) + ACC_W'(i);
  assign i_plus1  = ACC_W'(i) + ACC_W'(1);
  assign sum_acc  = ACC_W'(rd_sum) + ACC_W'(i);

  assign stat.top_zero    = (limit == '0);
  assign stat.j_at_top    = (j == top);
  assign stat.jn_over     = (j_plus_i > ACC_W'(top));
  assign stat.i_next_over = (i_plus1 > ACC_W'(top));

  assign rd_addr = cmd.load_query ? ADDR_W'(request.query_value) : j;
  assign we      = cmd.fill_wr | cmd.rmw_wr;

  always_comb begin
    if (cmd.fill_wr) begin
      wr_count = COUNT_W'(1);
      wr_sum   = SUM_W'(1);
    end else begin
      wr_count = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_W'(1);
      wr_sum   = (sum_acc > ACC_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(sum_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      count_mem[j] <= wr_count;
    end
    rd_count <= count_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      sum_mem[j] <= wr_sum;
    end
    rd_sum <= sum_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_build) begin
      top <= top_next;
      i   <= ADDR_W'(1);
      j   <= ADDR_W'(1);
    end else if (cmd.fill_wr) begin
      if (stat.j_at_top) begin
        i <= ADDR_W'(2);
        j <= ADDR_W'(2);
      end else begin
        j <= j + ADDR_W'(1);
      end
    end else if (cmd.rmw_wr) begin
      if (stat.jn_over) begin
        i <= ADDR_W'(i_plus1);
        j <= ADDR_W'(i_plus1);
      end else begin
        j <= ADDR_W'(j_plus_i);
      end
    end
    if (cmd.load_query) begin
      query_bad <= (q_ext == '0) || (q_ext > ACC_W'(built_limit)) ||
                   (q_ext > ACC_W'(MAX_N));
    end
    if (cmd.finish_build) begin
      result.divisor_count <= '0;
      result.divisor_sum   <= '0;
      result.status        <= ST_BUILT;
    end else if (cmd.finish_query) begin
      result.divisor_count <= query_bad ? '0 : rd_count;
      result.divisor_sum   <= query_bad ? '0 : rd_sum;
      result.status        <= query_bad ? ST_RANGE : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      built_limit <= '0;
      done        <= 1'b0;
    end else begin
      done <= cmd.finish_build | cmd.finish_query;
      if (cmd.finish_build) begin
        built_limit <= top;
      end
    end
  end

endmodule

### sv/divisor_count_sum_sieve_top.sv
// Top level of the divisor count and sum sieve: APB limit register,
// sequencer and table datapath. Depends on dcss_pkg, dcss_ctrl, dcss_datapath.
//
// Requests enter on request (func, query_value) and are taken at a clock
// edge with start high and busy low. Each request gives one result on
// result, marked by done for exactly one cycle; the receiver cannot stall.
// A query (func 1) reads both tables in one registered access: done rises
// in the cycle after the request edge, and busy holds off a new request
// until then. Value zero or a value above the built limit returns status 1.
// A build (func 0) takes top = min(limit, MAX_N) and fills the tables: the
// first divisor writes every entry from 1 to top once, and every later
// divisor i does a read and a write on each multiple; busy stays high and
// no new request is taken before done rises at the end of the build.
// Reset empties the tables logically (nothing built), restores limit to
// 65536 and returns the sequencer to idle; no clearing pass is needed.
// The limit register sits at byte address 0 of the APB port.
module divisor_count_sum_sieve_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  dcss_pkg::request_t            request,
  output logic                          busy,
  output logic                          done,
  output dcss_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcss_pkg::PADDR_W-1:0]  paddr,
  input  logic [dcss_pkg::PDATA_W-1:0]  pwdata,
  output logic [dcss_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import dcss_pkg::*;

  logic [LIMIT_W-1:0] limit;
  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic               ctrl_start;

  assign pready     = 1'b1;
  assign prdata     = (paddr == REG_LIMIT) ? PDATA_W'(limit) : '0;
  assign ctrl_start = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == REG_LIMIT)) begin
      limit <= pwdata[LIMIT_W-1:0];
    end
  end

  dcss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl_start),
    .func  (request.func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  dcss_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .limit   (limit),
    .stat    (stat),
    .result  (result),
    .done    (done)
  );

endmodule

### tb/divisor_count_sum_sieve_top_tb.sv
// Self-checking testbench for divisor_count_sum_sieve_top: table-driven directed
// requests, then random build/query phases checked against an in-bench sieve.
// Depends on dcss_pkg and the RTL of divisor_count_sum_sieve_top.
`timescale 1ns / 100ps

module divisor_count_sum_sieve_top_tb;
  import dcss_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int PLAN_LEN     = 25;

  typedef enum logic [1:0] {ROW_CFG, ROW_BUILD, ROW_QUERY} plan_kind_t;

  typedef struct {
    plan_kind_t          kind;
    logic [31:0]         arg;
    bit                  typed;
    logic [COUNT_W-1:0]  cnt;
    logic [SUM_W-1:0]    sum;
    logic [STATUS_W-1:0] st;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  request_t request;
  logic busy;
  logic done;
  result_t result;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  logic [COUNT_W-1:0] div_count_tab [0:MAX_N];
  logic [SUM_W-1:0]   div_sum_tab [0:MAX_N];
  int unsigned        built_top;
  logic [LIMIT_W-1:0] limit_shadow;

  result_t pending_results [$];
  result_t oldest;
  int      mismatches = 0;
  int      random_sent = 0;
  bit      burst_mode = 1'b0;

  plan_row_t directed_plan [PLAN_LEN] = '{
    '{ROW_QUERY, 0,      1, 0,  0,      ST_RANGE},
    '{ROW_QUERY, 1,      1, 0,  0,      ST_RANGE},
    '{ROW_QUERY, 65536,  1, 0,  0,      ST_RANGE},
    '{ROW_CFG,   0,      0, 0,  0,      ST_OK},
    '{ROW_BUILD, 0,      1, 0,  0,      ST_BUILT},
    '{ROW_QUERY, 1,      1, 0,  0,      ST_RANGE},
    '{ROW_CFG,   1,      0, 0,  0,      ST_OK},
    '{ROW_BUILD, 0,      1, 0,  0,      ST_BUILT},
    '{ROW_QUERY, 1,      1, 1,  1,      ST_OK},
    '{ROW_QUERY, 2,      1, 0,  0,      ST_RANGE},
    '{ROW_CFG,   12,     0, 0,  0,      ST_OK},
    '{ROW_BUILD, 0,      1, 0,  0,      ST_BUILT},
    '{ROW_QUERY, 12,     1, 6,  28,     ST_OK},
    '{ROW_QUERY, 7,      1, 2,  8,      ST_OK},
    '{ROW_QUERY, 13,     1, 0,  0,      ST_RANGE},
    '{ROW_QUERY, 0,      1, 0,  0,      ST_RANGE},
    '{ROW_QUERY, 131071, 1, 0,  0,      ST_RANGE},
    '{ROW_QUERY, 11,     0, 0,  0,      ST_OK},
    '{ROW_CFG,   131071, 0, 0,  0,      ST_OK},
    '{ROW_BUILD, 0,      1, 0,  0,      ST_BUILT},
    '{ROW_QUERY, 65536,  1, 17, 131071, ST_OK},
    '{ROW_QUERY, 55440,  0, 0,  0,      ST_OK},
    '{ROW_QUERY, 65535,  0, 0,  0,      ST_OK},
    '{ROW_QUERY, 65537,  1, 0,  0,      ST_RANGE},
    '{ROW_QUERY, 1,      1, 1,  1,      ST_OK}
  };

  divisor_count_sum_sieve_top dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  function automatic void rebuild_tables();
    int unsigned top;
    int unsigned i;
    int unsigned j;
    top = (limit_shadow > MAX_N) ? MAX_N : limit_shadow;
    for (j = 0; j <= top; j++) begin
      div_count_tab[j] = '0;
      div_sum_tab[j] = '0;
    end
    for (i = 1; i <= top; i++) begin
      for (j = i; j <= top; j += i) begin
        if (div_count_tab[j] != COUNT_MAX) div_count_tab[j] = div_count_tab[j] + 1'b1;
        if (div_sum_tab[j] > SUM_MAX - i) div_sum_tab[j] = SUM_MAX;
        else div_sum_tab[j] = div_sum_tab[j] + SUM_W'(i);
      end
    end
    built_top = top;
  endfunction

  function automatic result_t sieve_step(input request_t req);
    result_t res;
    res = '0;
    if (req.func == FUNC_BUILD) begin
      rebuild_tables();
      res.status = ST_BUILT;
    end else if (req.query_value == 0 || req.query_value > built_top) begin
      res.status = ST_RANGE;
    end else begin
      res.divisor_count = div_count_tab[req.query_value];
      res.divisor_sum = div_sum_tab[req.query_value];
      res.status = ST_OK;
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic issue(input logic f, input logic [LIMIT_W-1:0] v, input bit typed,
                       input result_t typed_res);
    request_t req;
    result_t pred;
    int gap;
    req.func = f;
    req.query_value = v;
    start <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    pred = sieve_step(req);
    pending_results = {pending_results, (typed ? typed_res : pred)};
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // write (optionally) then read back the limit register
  task automatic program_limit(input bit do_write, input logic [31:0] data);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_LIMIT;
    if (do_write) begin
      pwrite <= 1'b1;
      pwdata <= data;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      limit_shadow = data[LIMIT_W-1:0];
      penable <= 1'b0;
    end
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (prdata !== {{(PDATA_W-LIMIT_W){1'b0}}, limit_shadow}) begin
      flag_mismatch("limit readback", prdata, limit_shadow);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result, status", result.status, 0);
      end else begin
        oldest = pending_results.pop_front();
        if (result.divisor_count !== oldest.divisor_count)
          flag_mismatch("divisor_count", result.divisor_count, oldest.divisor_count);
        if (result.divisor_sum !== oldest.divisor_sum)
          flag_mismatch("divisor_sum", result.divisor_sum, oldest.divisor_sum);
        if (result.status !== oldest.status)
          flag_mismatch("status", result.status, oldest.status);
      end
    end
  end

  initial begin
    #250_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    result_t typed_res;
    logic [LIMIT_W-1:0] lim;
    logic [LIMIT_W-1:0] qv;
    logic [14:0] junk;
    int nq;
    int r;

    rst <= 1'b1;
    start <= 1'b0;
    request <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_LIMIT;
    pwdata <= '0;
    built_top = 0;
    limit_shadow = LIMIT_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    program_limit(1'b0, '0);

    foreach (directed_plan[k]) begin
      typed_res.divisor_count = directed_plan[k].cnt;
      typed_res.divisor_sum = directed_plan[k].sum;
      typed_res.status = directed_plan[k].st;
      case (directed_plan[k].kind)
        ROW_CFG: begin
          program_limit(1'b1, directed_plan[k].arg);
        end
        ROW_BUILD: begin
          issue(FUNC_BUILD, '0, directed_plan[k].typed, typed_res);
        end
        default: begin
          issue(FUNC_QUERY, directed_plan[k].arg[LIMIT_W-1:0], directed_plan[k].typed,
                typed_res);
        end
      endcase
    end

    // probe the full-size table across the whole value range
    typed_res = '0;
    repeat (300) begin
      r = $urandom_range(0, 9);
      if (r == 0) qv = '0;
      else if (r == 1) qv = LIMIT_W'($urandom_range(65537, 131071));
      else if (r == 2) qv = LIMIT_W'($urandom_range(65500, 65536));
      else qv = LIMIT_W'($urandom_range(1, 65536));
      issue(FUNC_QUERY, qv, 1'b0, typed_res);
      random_sent++;
    end

    while (random_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r == 0) lim = '0;
      else if (r == 1) lim = LIMIT_W'(1);
      else if (r == 2) lim = LIMIT_W'($urandom_range(1000, 2500));
      else lim = LIMIT_W'($urandom_range(2, 150));
      junk = 15'($urandom_range(0, 32767));
      program_limit(1'b1, {junk, lim});
      burst_mode = ($urandom_range(0, 3) == 0);
      issue(FUNC_BUILD, LIMIT_W'($urandom_range(0, 131071)), 1'b0, typed_res);
      random_sent++;
      nq = $urandom_range(5, 50);
      repeat (nq) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          issue(FUNC_BUILD, LIMIT_W'($urandom_range(0, 131071)), 1'b0, typed_res);
        end else begin
          if (r == 1) qv = '0;
          else if (r == 2) qv = LIMIT_W'($urandom_range(0, 131071));
          else if (r <= 4) qv = lim + LIMIT_W'($urandom_range(1, 3));
          else if (lim == 0) qv = LIMIT_W'($urandom_range(1, 5));
          else qv = LIMIT_W'($urandom_range(1, lim));
          issue(FUNC_QUERY, qv, 1'b0, typed_res);
        end
        random_sent++;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
